### sv/assert_macros.svh
// Assertion macros for the speed PI block.
// Both sample on clk_i; the first one is masked while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked out of reset only
`define SPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/spg_pkg.sv
// Shared types and constants of the speed PI block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package spg_pkg;

  // history depth default
  localparam int unsigned HIST_DEPTH = 16;

  // datapath widths
  localparam int unsigned ERR_W    = 17;  // signed speed error, mm/s
  localparam int unsigned INT_W    = 34;  // clamped integral, mm Q16
  localparam int unsigned ACC_W    = 62;  // multiplier accumulator
  localparam int unsigned MAG_W    = 49;  // clamped drive magnitude, Q40
  localparam int unsigned MPLIER_W = 16;
  localparam int unsigned STEP_W   = 5;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned DRV_FRAC = 40;

  // shift-add pass lengths
  localparam logic [STEP_W-1:0] STEPS_FULL  = STEP_W'(16);
  localparam logic [STEP_W-1:0] STEPS_SLOPE = STEP_W'(10);

  // magnitude clamp 255 in Q40
  localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(255) << DRV_FRAC;

  // register indexes
  localparam logic [IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PROP     = 3'd1;
  localparam logic [IDX_W-1:0] REG_INTEG    = 3'd2;
  localparam logic [IDX_W-1:0] REG_INT_LIM  = 3'd3;
  localparam logic [IDX_W-1:0] REG_PERIOD   = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOLD_LIM = 3'd5;
  localparam logic [IDX_W-1:0] REG_JUMP_LIM = 3'd6;
  localparam logic [IDX_W-1:0] REG_WINDOW   = 3'd7;

  // command codes
  localparam logic CMD_STEP = 1'b0;
  localparam logic CMD_HALT = 1'b1;

  // multiplier control and status
  typedef struct packed {
    logic              load;
    logic [STEP_W-1:0] steps;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
  } mul_sts_t;

  // oscillation guard control and status
  typedef struct packed {
    logic push;
    logic clear;
  } grd_ctl_t;

  typedef struct packed {
    logic busy;
    logic osc;
  } grd_sts_t;

endpackage

### sv/spg_mul.sv
// Shared shift-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on spg_pkg for widths and the control structs.
`timescale 1ns / 1ps

module spg_mul (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  spg_pkg::mul_ctl_t                     ctl_i,
  input  logic signed [spg_pkg::ACC_W-1:0]      mcand_i,
  input  logic        [spg_pkg::MPLIER_W-1:0]   mplier_i,
  input  logic signed [spg_pkg::ACC_W-1:0]      acc_i,
  output logic signed [spg_pkg::ACC_W-1:0]      acc_o,
  output spg_pkg::mul_sts_t                     sts_o
);

  logic signed [spg_pkg::ACC_W-1:0]    mcand_q;
  logic        [spg_pkg::MPLIER_W-1:0] mplier_q;
  logic signed [spg_pkg::ACC_W-1:0]    acc_q;
  logic        [spg_pkg::STEP_W-1:0]   cnt_q;
  logic                                busy_q;

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (ctl_i.load) begin
      cnt_q  <= ctl_i.steps;
      busy_q <= (ctl_i.steps != '0);
    end else if (busy_q) begin
      cnt_q <= cnt_q - spg_pkg::STEP_W'(1);
      if (cnt_q == spg_pkg::STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operand shift and accumulate
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= acc_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign acc_o      = acc_q;
  assign sts_o.busy = busy_q;

endmodule

### sv/spg_guard.sv
// Oscillation guard: steering history shift line and a serial jump counter.
// Depends on spg_pkg for the control and status structs.
`timescale 1ns / 1ps

module spg_guard #(
  parameter int unsigned DEPTH = spg_pkg::HIST_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spg_pkg::grd_ctl_t  ctl_i,
  input  logic signed [15:0] steer_i,
  input  logic [15:0]        jump_limit_i,
  input  logic [4:0]         guard_window_i,
  output spg_pkg::grd_sts_t  sts_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned WW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int unsigned SC_W  = $clog2(DEPTH);
  localparam int unsigned NF    = DEPTH - 1;

  typedef enum logic [1:0] {G_IDLE, G_LOAD, G_SCAN} grd_state_e;

  grd_state_e         state_q;
  logic signed [15:0] hist_q [DEPTH];
  logic [CNT_W-1:0]   cnt_q;
  logic [NF-1:0]      flags_q;
  logic [CNT_W-1:0]   jumps_q;
  logic [SC_W-1:0]    idx_q;
  logic               osc_q;

  logic [WW-1:0]      gw_w;
  logic [WW-1:0]      win_w;
  logic [CNT_W-1:0]   win;
  logic [CNT_W:0]     cnt_inc;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   jumps_nxt;
  logic signed [16:0] diff [NF];
  logic [16:0]        dmag [NF];
  logic [NF-1:0]      flags;

  // effective window: zero acts as one, capped at the depth
  always_comb begin
    gw_w = WW'(guard_window_i);
    if (gw_w == '0) begin
      win_w = WW'(1);
    end else if (gw_w > WW'(DEPTH)) begin
      win_w = WW'(DEPTH);
    end else begin
      win_w = gw_w;
    end
    win = win_w[CNT_W-1:0];
  end

  // fill count after a push
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + (CNT_W + 1)'(1);
    if (cnt_inc > {1'b0, win}) begin
      cnt_nxt = cnt_q;
    end else begin
      cnt_nxt = cnt_inc[CNT_W-1:0];
    end
  end

  // large jump between neighbors, only inside the filled part
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      diff[i]  = {hist_q[i+1][15], hist_q[i+1]} - {hist_q[i][15], hist_q[i]};
      dmag[i]  = diff[i][16] ? 17'(-diff[i]) : 17'(diff[i]);
      flags[i] = (dmag[i] > {1'b0, jump_limit_i}) && (CNT_W'(i + 1) < cnt_q);
    end
  end

  assign jumps_nxt = jumps_q + CNT_W'(flags_q[0]);

  // history shift line, newest at entry zero
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      hist_q[0] <= steer_i;
      for (int i = 1; i < DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // scan sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      cnt_q   <= '0;
      flags_q <= '0;
      jumps_q <= '0;
      idx_q   <= '0;
      osc_q   <= 1'b0;
    end else begin
      case (state_q)
        G_IDLE: begin
          if (ctl_i.clear) begin
            cnt_q <= '0;
            osc_q <= 1'b0;
          end else if (ctl_i.push) begin
            cnt_q   <= cnt_nxt;
            state_q <= G_LOAD;
          end
        end
        G_LOAD: begin
          flags_q <= flags;
          jumps_q <= '0;
          idx_q   <= SC_W'(NF);
          state_q <= G_SCAN;
        end
        G_SCAN: begin
          jumps_q <= jumps_nxt;
          flags_q <= flags_q >> 1;
          idx_q   <= idx_q - SC_W'(1);
          if (idx_q == SC_W'(1)) begin
            osc_q   <= (cnt_q >= win) && (jumps_nxt >= (win >> 1));
            state_q <= G_IDLE;
          end
        end
        default: state_q <= G_IDLE;
      endcase
    end
  end

  assign sts_o.busy = (state_q != G_IDLE);
  assign sts_o.osc  = osc_q;

endmodule

### sv/speed_pi_with_oscillation_guard_unit.sv
// Top level of the speed PI controller with path hold and oscillation guard.
// Depends on spg_pkg, spg_mul, spg_guard and assert_macros.svh.
//
// One beat in gives one beat out. A control step runs through a single
// shift-add multiply-accumulate unit four times: integral update, integral
// term, proportional term and slope scaling, with 16, 16, 16 and 10
// multiplier bits, one bit per cycle. Each pass is loaded and then handed
// off. The integral is clamped after the first pass; a magnitude step and
// an output step follow the last. The magnitude step also waits for the
// history scan, which runs alongside the multiply passes. A receiver stall
// on a still-waiting earlier result holds the output step. A halt beat
// clears the integral and the held steering and emits a zero result.
// The input stalls while a step is under way; a finished result waits in
// the output register while the next input beat is taken. Speeds are mm/s,
// gains Q16, slope Q2.8, and drive is rounded half away from zero to
// -255..255, and halved while the guard flags oscillation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module speed_pi_with_oscillation_guard_unit #(
  parameter int unsigned HISTORY_DEPTH = spg_pkg::HIST_DEPTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [spg_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [spg_pkg::CFG_W-1:0]       cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            command_i,
  input  logic signed [16:0]              lateral_error_i,
  input  logic signed [15:0]              steer_cmd_i,
  input  logic [14:0]                     ground_speed_i,
  input  logic                            reverse_i,
  input  logic [9:0]                      slope_gain_i,
  // result channel
  output logic                            res_valid_o,
  input  logic                            res_stall_i,
  output logic signed [8:0]               drive_o,
  output logic signed [15:0]              steer_out_o,
  output logic                            out_valid_o,
  output logic                            holding_o,
  output logic                            oscillating_o
);

  localparam int unsigned ERR_W = spg_pkg::ERR_W;
  localparam int unsigned INT_W = spg_pkg::INT_W;
  localparam int unsigned ACC_W = spg_pkg::ACC_W;
  localparam int unsigned MAG_W = spg_pkg::MAG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_CLAMP, S_INTG, S_PROP, S_SLOPE, S_MAG, S_EMIT, S_HALT
  } seq_state_e;

  // configuration registers
  logic [13:0] target_speed_q;
  logic [15:0] prop_gain_q;
  logic [15:0] integ_gain_q;
  logic [15:0] integral_limit_q;
  logic [15:0] tick_period_q;
  logic [15:0] hold_limit_q;
  logic [15:0] jump_limit_q;
  logic [4:0]  guard_window_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_speed_q   <= 14'd833;
      prop_gain_q      <= 16'd1966;
      integ_gain_q     <= 16'd131;
      integral_limit_q <= 16'd15000;
      tick_period_q    <= 16'd3277;
      hold_limit_q     <= 16'd2000;
      jump_limit_q     <= 16'd2000;
      guard_window_q   <= 5'd6;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spg_pkg::REG_TARGET:   target_speed_q   <= cfg_data_i[13:0];
        spg_pkg::REG_PROP:     prop_gain_q      <= cfg_data_i;
        spg_pkg::REG_INTEG:    integ_gain_q     <= cfg_data_i;
        spg_pkg::REG_INT_LIM:  integral_limit_q <= cfg_data_i;
        spg_pkg::REG_PERIOD:   tick_period_q    <= cfg_data_i;
        spg_pkg::REG_HOLD_LIM: hold_limit_q     <= cfg_data_i;
        spg_pkg::REG_JUMP_LIM: jump_limit_q     <= cfg_data_i;
        spg_pkg::REG_WINDOW:   guard_window_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // sequencer state and registered results
  seq_state_e                state_q;
  logic                      load_q;
  logic                      load_d;
  logic signed [ERR_W-1:0]   err_q;
  logic                      hold_q;
  logic signed [15:0]        steer_q;
  logic [9:0]                slope_q;
  logic signed [INT_W-1:0]   integral_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      neg_q;
  logic signed [15:0]        dsteer_q;
  logic                      dvalid_q;
  logic                      res_valid_q;
  logic                      res_valid_d;
  logic signed [8:0]         drive_q;
  logic signed [15:0]        steer_out_q;
  logic                      out_valid_q;
  logic                      holding_q;
  logic                      osc_out_q;

  // multiplier and guard hookup
  spg_pkg::mul_ctl_t                 mul_ctl;
  spg_pkg::mul_sts_t                 mul_sts;
  logic signed [ACC_W-1:0]           mul_mcand;
  logic [spg_pkg::MPLIER_W-1:0]      mul_mplier;
  logic signed [ACC_W-1:0]           mul_acc_in;
  logic signed [ACC_W-1:0]           acc;
  spg_pkg::grd_ctl_t                 grd_ctl;
  spg_pkg::grd_sts_t                 grd_sts;

  logic                     in_acc;
  logic                     mul_done;
  logic                     slot_free;
  logic                     emit;
  logic signed [ERR_W-1:0]  err_raw;
  logic signed [ERR_W-1:0]  err_in;
  logic [16:0]              lat_mag;
  logic                     hold_in;
  logic signed [ACC_W-1:0]  lim_pos;
  logic signed [ACC_W-1:0]  lim_neg;
  logic signed [ACC_W-1:0]  int_clamped;
  logic [ACC_W-1:0]         acc_mag;
  logic [MAG_W-1:0]         mag_clamped;
  logic [MAG_W:0]           rnd_sum;
  logic [8:0]               rnd;
  logic signed [8:0]        drive_nxt;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign mul_done  = !load_q && !mul_sts.busy;
  assign slot_free = !res_valid_q || !res_stall_i;

  // signed speed error and path hold test on the incoming beat
  always_comb begin
    err_raw = ERR_W'({3'b000, target_speed_q}) - ERR_W'({2'b00, ground_speed_i});
    err_in  = reverse_i ? -err_raw : err_raw;
    lat_mag = lateral_error_i[16] ? 17'(-lateral_error_i) : 17'(lateral_error_i);
    hold_in = lat_mag > {1'b0, hold_limit_q};
  end

  // multiplier load strobe and result register valid
  always_comb begin
    emit   = ((state_q == S_EMIT) || (state_q == S_HALT)) && slot_free;
    load_d = 1'b0;
    case (state_q)
      S_IDLE:  load_d = in_acc && (command_i == spg_pkg::CMD_STEP);
      S_CLAMP: load_d = 1'b1;
      S_INTG,
      S_PROP:  load_d = mul_done;
      default: load_d = 1'b0;
    endcase
    if (emit) begin
      res_valid_d = 1'b1;
    end else if (res_valid_q && !res_stall_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  // operand selection for each multiplier pass
  always_comb begin
    mul_ctl.load  = load_q;
    mul_ctl.steps = spg_pkg::STEPS_FULL;
    mul_mcand     = '0;
    mul_mplier    = '0;
    mul_acc_in    = '0;
    case (state_q)
      S_TICK: begin
        mul_mcand  = {{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q};
        mul_mplier = tick_period_q;
        mul_acc_in = {{(ACC_W-INT_W){integral_q[INT_W-1]}}, integral_q};
      end
      S_INTG: begin
        mul_mcand  = {{(ACC_W-INT_W){integral_q[INT_W-1]}}, integral_q};
        mul_mplier = integ_gain_q;
      end
      S_PROP: begin
        mul_mcand  = {{(ACC_W-ERR_W-16){err_q[ERR_W-1]}}, err_q, 16'h0000};
        mul_mplier = prop_gain_q;
        mul_acc_in = acc;
      end
      S_SLOPE: begin
        mul_mcand     = acc;
        mul_mplier    = {6'b000000, slope_q};
        mul_ctl.steps = spg_pkg::STEPS_SLOPE;
      end
      default: ;
    endcase
  end

  // integral clamp to +-limit in Q16
  always_comb begin
    lim_pos = {{(ACC_W-32){1'b0}}, integral_limit_q, 16'h0000};
    lim_neg = -lim_pos;
    if (acc > lim_pos) begin
      int_clamped = lim_pos;
    end else if (acc < lim_neg) begin
      int_clamped = lim_neg;
    end else begin
      int_clamped = acc;
    end
  end

  // drive magnitude clamp, then round half up at bit 40 or 41
  always_comb begin
    acc_mag     = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    mag_clamped = (acc_mag > ACC_W'(spg_pkg::MAG_MAX)) ? spg_pkg::MAG_MAX
                                                        : acc_mag[MAG_W-1:0];
    if (grd_sts.osc) begin
      rnd_sum = {1'b0, mag_q} + ((MAG_W + 1)'(1) << spg_pkg::DRV_FRAC);
      rnd     = rnd_sum[MAG_W:spg_pkg::DRV_FRAC+1];
    end else begin
      rnd_sum = {1'b0, mag_q} + ((MAG_W + 1)'(1) << (spg_pkg::DRV_FRAC - 1));
      rnd     = rnd_sum[spg_pkg::DRV_FRAC+8:spg_pkg::DRV_FRAC];
    end
    drive_nxt = neg_q ? -$signed(rnd) : $signed(rnd);
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      load_q      <= 1'b0;
      err_q       <= '0;
      hold_q      <= 1'b0;
      steer_q     <= '0;
      slope_q     <= '0;
      integral_q  <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      dsteer_q    <= '0;
      dvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
      drive_q     <= '0;
      steer_out_q <= '0;
      out_valid_q <= 1'b0;
      holding_q   <= 1'b0;
      osc_out_q   <= 1'b0;
    end else begin
      load_q      <= load_d;
      res_valid_q <= res_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            if (command_i == spg_pkg::CMD_HALT) begin
              integral_q <= '0;
              dsteer_q   <= '0;
              dvalid_q   <= 1'b0;
              state_q    <= S_HALT;
            end else begin
              err_q   <= err_in;
              hold_q  <= hold_in;
              steer_q <= steer_cmd_i;
              slope_q <= slope_gain_i;
              state_q <= S_TICK;
            end
          end
        end
        S_TICK: begin
          if (mul_done) begin
            state_q <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          integral_q <= int_clamped[INT_W-1:0];
          state_q    <= S_INTG;
        end
        S_INTG: begin
          if (mul_done) begin
            state_q <= S_PROP;
          end
        end
        S_PROP: begin
          if (mul_done) begin
            state_q <= S_SLOPE;
          end
        end
        S_SLOPE: begin
          if (mul_done) begin
            state_q <= S_MAG;
          end
        end
        S_MAG: begin
          // wait for the history scan as well
          if (!grd_sts.busy) begin
            neg_q <= acc[ACC_W-1];
            if (hold_q) begin
              mag_q      <= '0;
              integral_q <= '0;
            end else begin
              mag_q <= mag_clamped;
            end
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            drive_q     <= drive_nxt;
            steer_out_q <= dvalid_q ? dsteer_q : 16'sd0;
            out_valid_q <= dvalid_q;
            holding_q   <= hold_q;
            osc_out_q   <= grd_sts.osc;
            dsteer_q    <= steer_q;
            dvalid_q    <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_HALT: begin
          if (slot_free) begin
            drive_q     <= '0;
            steer_out_q <= '0;
            out_valid_q <= 1'b0;
            holding_q   <= 1'b0;
            osc_out_q   <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign grd_ctl.push  = in_acc && (command_i == spg_pkg::CMD_STEP);
  assign grd_ctl.clear = in_acc && (command_i == spg_pkg::CMD_HALT);

  spg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mul_ctl),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .acc_i    (mul_acc_in),
    .acc_o    (acc),
    .sts_o    (mul_sts)
  );

  spg_guard #(
    .DEPTH (HISTORY_DEPTH)
  ) u_guard (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (grd_ctl),
    .steer_i        (steer_cmd_i),
    .jump_limit_i   (jump_limit_q),
    .guard_window_i (guard_window_q),
    .sts_o          (grd_sts)
  );

  assign in_stall_o    = (state_q != S_IDLE);
  assign res_valid_o   = res_valid_q;
  assign drive_o       = drive_q;
  assign steer_out_o   = steer_out_q;
  assign out_valid_o   = out_valid_q;
  assign holding_o     = holding_q;
  assign oscillating_o = osc_out_q;

  // checks
  `SPG_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !res_valid_o && !mul_sts.busy, "active in reset")
  `SPG_ASSERT(a_idle_mul_quiet, !in_stall_o |-> !mul_sts.busy && !load_q, "multiplier busy while sequencer idle")
  `SPG_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> in_stall_o, "input taken but sequencer not busy")
  `SPG_ASSERT(a_hold_zero, res_valid_o && holding_o |-> drive_o == 9'sd0, "drive not zero under path hold")
  `SPG_ASSERT(a_osc_half, res_valid_o && oscillating_o |-> (drive_o <= 9'sd128) && (drive_o >= -9'sd128), "halved drive out of range")

endmodule

### dv/speed_pi_with_oscillation_guard_unit_tb.sv
// Self-checking bench for the speed PI unit with path hold and oscillation guard.
// Needs spg_pkg and speed_pi_with_oscillation_guard_unit; drives both channels and the
// register port, predicts every result beat in place and compares field by field.
`timescale 1ns / 1ps

module speed_pi_with_oscillation_guard_unit_tb;

  localparam int HIST            = spg_pkg::HIST_DEPTH;
  localparam int NUM_DIRECTED    = 16;
  localparam int NUM_PHASES      = 12;
  localparam int TICKS_PER_PHASE = 42;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 80;
  localparam longint unsigned DRIVE_CAP_Q40 = 64'd255 << 40;

  // one control tick as it goes in
  typedef struct packed {
    logic               command;
    logic signed [16:0] lat;
    logic signed [15:0] steer;
    logic [14:0]        ground;
    logic               reverse;
    logic [9:0]         slope;
  } tick_t;

  // one result beat
  typedef struct packed {
    logic signed [8:0]  drive;
    logic signed [15:0] steer_out;
    logic               out_valid;
    logic               holding;
    logic               oscillating;
  } drive_beat_t;

  // directed row: stimulus plus an optional hand-written result
  typedef struct packed {
    tick_t       stim;
    logic        typed;
    drive_beat_t want;
  } dir_row_t;

  localparam drive_beat_t ALL_ZERO = '0;

  // Default registers throughout. Typed rows: halts, idle steps right after a halt,
  // and path-hold steps whose drive is forced to zero.
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{spg_pkg::CMD_HALT, 17'sd12345, 16'sd777, 15'd100, 1'b1, 10'd1023}, 1'b1, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sd0, 16'sd0, 15'd0, 1'b0, 10'd0}, 1'b1, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sh10000, 16'sd18000, 15'd32767, 1'b1, 10'd1023}, 1'b1,
      '{9'sd0, 16'sd0, 1'b1, 1'b1, 1'b0}},
    '{'{spg_pkg::CMD_STEP, 17'sd65535, -16'sd18000, 15'd0, 1'b0, 10'd1023}, 1'b1,
      '{9'sd0, 16'sd18000, 1'b1, 1'b1, 1'b0}},
    '{'{spg_pkg::CMD_STEP, 17'sd2000, 16'sd18000, 15'd0, 1'b0, 10'd1023}, 1'b0, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, -17'sd2000, -16'sd18000, 15'd32767, 1'b0, 10'd1023}, 1'b0,
      ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sd0, 16'sd18000, 15'd833, 1'b1, 10'd1023}, 1'b0, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, -17'sd2001, 16'sd0, 15'd0, 1'b1, 10'd512}, 1'b0, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sd1, 16'sd17999, 15'd400, 1'b1, 10'd256}, 1'b0, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, -17'sd1, -16'sd1, 15'd1, 1'b0, 10'd1}, 1'b0, ALL_ZERO},
    '{'{spg_pkg::CMD_HALT, 17'sh10000, -16'sd18000, 15'd32767, 1'b0, 10'd0}, 1'b1, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sd0, 16'sd5, 15'd0, 1'b0, 10'd0}, 1'b1, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sd0, -16'sd5, 15'd21845, 1'b0, 10'd682}, 1'b0, ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, -17'sd43691, 16'sd4000, 15'd10922, 1'b1, 10'd341}, 1'b0,
      ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, 17'sd1365, 16'sd10922, 15'd10922, 1'b0, 10'd341}, 1'b0,
      ALL_ZERO},
    '{'{spg_pkg::CMD_STEP, -17'sd1366, -16'sd10923, 15'd32767, 1'b1, 10'd682}, 1'b0,
      ALL_ZERO}
  };

  // DUT ports
  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [spg_pkg::IDX_W-1:0]   cfg_idx_i;
  logic [spg_pkg::CFG_W-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        command_i;
  logic signed [16:0]          lateral_error_i;
  logic signed [15:0]          steer_cmd_i;
  logic [14:0]                 ground_speed_i;
  logic                        reverse_i;
  logic [9:0]                  slope_gain_i;
  logic                        res_valid_o;
  logic                        res_stall_i = 1'b0;
  logic signed [8:0]           drive_o;
  logic signed [15:0]          steer_out_o;
  logic                        out_valid_o;
  logic                        holding_o;
  logic                        oscillating_o;

  // register copies, reset values
  logic [13:0] target_mm_s  = 14'd833;
  logic [15:0] kp_q16       = 16'd1966;
  logic [15:0] ki_q16       = 16'd131;
  logic [15:0] int_limit_mm = 16'd15000;
  logic [15:0] period_q16   = 16'd3277;
  logic [15:0] hold_mm      = 16'd2000;
  logic [15:0] jump_cdeg    = 16'd2000;
  logic [4:0]  guard_win    = 5'd6;

  // controller state as predicted
  longint             integral_q16 = 0;
  logic signed [15:0] steer_hist [HIST];
  int                 hist_count = 0;
  logic signed [15:0] held_steer = '0;
  logic               held_valid = 1'b0;

  drive_beat_t predicted_drive_q [$];
  int          fail_count  = 0;
  int          send_idle_pct = 0;
  int          stall_pct   = 0;
  int          last_steer  = 0;

  speed_pi_with_oscillation_guard_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // receiver back-pressure
  always @(posedge clk_i) begin
    res_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // PI step, path hold and oscillation guard for one tick
  function automatic drive_beat_t compute_drive(input tick_t t);
    drive_beat_t     r;
    longint          err, lat, lim, u, d, rnd_s;
    longint unsigned mag, rnd;
    int              win, jumps, shift_amt, i;
    logic            hold, osc, neg;
    r = '0;
    if (t.command == spg_pkg::CMD_HALT) begin
      integral_q16 = 0;
      hist_count   = 0;
      held_steer   = '0;
      held_valid   = 1'b0;
      return r;
    end
    err = longint'(target_mm_s) - longint'(t.ground);
    if (t.reverse) err = -err;
    lat  = longint'(t.lat);
    hold = ((lat < 0) ? -lat : lat) > longint'(hold_mm);

    // guard: push newest, trim by at most one, scan adjacent jumps
    win = int'(guard_win);
    if (win == 0) win = 1;
    if (win > HIST) win = HIST;
    for (i = HIST - 1; i > 0; i--) steer_hist[i] = steer_hist[i-1];
    steer_hist[0] = t.steer;
    hist_count++;
    if (hist_count > win) hist_count--;
    if (hist_count > HIST) hist_count = HIST;
    osc = 1'b0;
    if (hist_count >= win) begin
      jumps = 0;
      for (i = 1; i < hist_count; i++) begin
        d = longint'(steer_hist[i]) - longint'(steer_hist[i-1]);
        if (d < 0) d = -d;
        if (d > longint'(jump_cdeg)) jumps++;
      end
      osc = (jumps >= win / 2);
    end

    // integral with symmetric clamp, then drive in Q40
    integral_q16 += err * longint'(period_q16);
    lim = longint'(int_limit_mm) * 65536;
    if (integral_q16 > lim) integral_q16 = lim;
    if (integral_q16 < -lim) integral_q16 = -lim;
    u = (err * longint'(kp_q16) * 65536 + longint'(ki_q16) * integral_q16)
        * longint'(t.slope);
    neg = (u < 0);
    mag = neg ? -u : u;
    if (mag > DRIVE_CAP_Q40) mag = DRIVE_CAP_Q40;
    if (hold) begin
      mag = 0;
      integral_q16 = 0;
    end
    shift_amt = osc ? 41 : 40;
    rnd   = (mag + (64'd1 << (shift_amt - 1))) >> shift_amt;
    rnd_s = neg ? -longint'(rnd) : longint'(rnd);

    r.drive       = rnd_s[8:0];
    r.steer_out   = held_valid ? held_steer : '0;
    r.out_valid   = held_valid;
    r.holding     = hold;
    r.oscillating = osc;
    held_steer = t.steer;
    held_valid = 1'b1;
    return r;
  endfunction

  // mostly plausible ticks: alternating big steers, drift near the jump limit,
  // errors near the hold limit, speeds near target; a few halts
  function automatic tick_t random_tick();
    tick_t t;
    int    r, s, j, h, lat, g;
    t.command = ($urandom_range(99) < 4) ? spg_pkg::CMD_HALT : spg_pkg::CMD_STEP;
    r = $urandom_range(99);
    j = int'(jump_cdeg) + 64;
    if (r < 45)
      s = (last_steer >= 0) ? -int'($urandom_range(18000)) : int'($urandom_range(18000));
    else if (r < 75)
      s = last_steer + int'($urandom_range(2 * j)) - j;
    else if (r < 80)
      s = r[0] ? 18000 : -18000;
    else
      s = int'($urandom_range(36000)) - 18000;
    if (s > 18000) s = 18000;
    if (s < -18000) s = -18000;
    last_steer = s;

    h = int'(hold_mm) + 1;
    if ($urandom_range(99) < 75) lat = int'($urandom_range(2 * h)) - h;
    else lat = int'($urandom_range(131071)) - 65536;
    if (lat > 65535) lat = 65535;
    if (lat < -65536) lat = -65536;

    if ($urandom_range(1) == 1) g = int'(target_mm_s) + int'($urandom_range(400)) - 200;
    else g = int'($urandom_range(32767));
    if (g < 0) g = 0;
    if (g > 32767) g = 32767;

    r = $urandom_range(9);
    t.slope   = (r == 0) ? 10'd0 : (r == 1) ? 10'd1023 : (r == 2) ? 10'd256
              : 10'($urandom_range(1023));
    t.lat     = 17'(lat);
    t.steer   = 16'(s);
    t.ground  = 15'(g);
    t.reverse = 1'($urandom_range(1));
    return t;
  endfunction

  // one input beat, with random idle cycles ahead of it
  task automatic send_tick(input tick_t t, input logic typed, input drive_beat_t want);
    drive_beat_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= t.command;
    lateral_error_i <= t.lat;
    steer_cmd_i     <= t.steer;
    ground_speed_i  <= t.ground;
    reverse_i       <= t.reverse;
    slope_gain_i    <= t.slope;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    r = compute_drive(t);
    predicted_drive_q.insert(predicted_drive_q.size(), typed ? want : r);
  endtask

  task automatic write_reg(input logic [spg_pkg::IDX_W-1:0] idx,
                           input logic [spg_pkg::CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      spg_pkg::REG_TARGET:   target_mm_s  = val[13:0];
      spg_pkg::REG_PROP:     kp_q16       = val;
      spg_pkg::REG_INTEG:    ki_q16       = val;
      spg_pkg::REG_INT_LIM:  int_limit_mm = val;
      spg_pkg::REG_PERIOD:   period_q16   = val;
      spg_pkg::REG_HOLD_LIM: hold_mm      = val;
      spg_pkg::REG_JUMP_LIM: jump_cdeg    = val;
      spg_pkg::REG_WINDOW:   guard_win    = val[4:0];
      default: ;
    endcase
  endtask

  // phase 0 all maxima, 1 all zero, 2 reset values, later a random mix
  function automatic logic [spg_pkg::CFG_W-1:0] pick_setting(input int p, input int hi,
                                                             input int dflt);
    int k;
    k = $urandom_range(3);
    if (p == 0) return spg_pkg::CFG_W'(hi);
    if (p == 1) return '0;
    if (p == 2 || k == 1) return spg_pkg::CFG_W'(dflt);
    if (k == 0) return spg_pkg::CFG_W'(hi);
    return spg_pkg::CFG_W'($urandom_range(hi) >> $urandom_range(8));
  endfunction

  task automatic apply_setting(input int p);
    logic [spg_pkg::CFG_W-1:0] win;
    if (p == 0) win = 16'd31;
    else if (p == 1) win = '0;
    else if (p == 2) win = 16'd16;
    else if ($urandom_range(3) == 0) win = spg_pkg::CFG_W'($urandom_range(31));
    else win = spg_pkg::CFG_W'($urandom_range(1, 8));
    write_reg(spg_pkg::REG_TARGET,   pick_setting(p, 16000, 833));
    write_reg(spg_pkg::REG_PROP,     pick_setting(p, 65535, 1966));
    write_reg(spg_pkg::REG_INTEG,    pick_setting(p, 65535, 131));
    write_reg(spg_pkg::REG_INT_LIM,  pick_setting(p, 65535, 15000));
    write_reg(spg_pkg::REG_PERIOD,   pick_setting(p, 65535, 3277));
    write_reg(spg_pkg::REG_HOLD_LIM, pick_setting(p, 65535, 2000));
    write_reg(spg_pkg::REG_JUMP_LIM, pick_setting(p, 36000, 2000));
    write_reg(spg_pkg::REG_WINDOW,   win);
    cfg_we_i <= 1'b0;
  endtask

  // no idling, sender idle, receiver stalling, both
  task automatic set_idling(input int mode);
    send_idle_pct = (mode == 1) ? 76 : (mode == 3) ? 34 : 0;
    stall_pct     = (mode == 2) ? 76 : (mode == 3) ? 34 : 0;
  endtask

  task automatic wait_drained();
    while (predicted_drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    drive_beat_t want;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      if (predicted_drive_q.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = predicted_drive_q[0];
        predicted_drive_q.delete(0);
        check_field("drive", drive_o, want.drive);
        check_field("steer_out", steer_out_o, want.steer_out);
        check_field("out_valid", out_valid_o, want.out_valid);
        check_field("holding", holding_o, want.holding);
        check_field("oscillating", oscillating_o, want.oscillating);
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int k, p, n;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = spg_pkg::REG_TARGET;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    command_i       = spg_pkg::CMD_STEP;
    lateral_error_i = '0;
    steer_cmd_i     = '0;
    ground_speed_i  = '0;
    reverse_i       = 1'b0;
    slope_gain_i    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset register values
    set_idling(0);
    for (k = 0; k < NUM_DIRECTED; k++)
      send_tick(DIRECTED_ROWS[k].stim, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);

    // random phases, each with its own registers and idling
    for (p = 0; p < NUM_PHASES; p++) begin
      in_valid_i <= 1'b0;
      wait_drained();
      apply_setting(p);
      set_idling(p % 4);
      for (n = 0; n < TICKS_PER_PHASE; n++) send_tick(random_tick(), 1'b0, ALL_ZERO);
    end
    in_valid_i <= 1'b0;

    while (predicted_drive_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && predicted_drive_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
